[sv/div64_pkg.sv]
// Package with shared types and constants for the 64-bit divider.
`default_nettype none
package div64_pkg;
  localparam int DataWidth = 64;
  localparam int StepBits = 4;
  localparam int NumSteps = DataWidth / StepBits;
  localparam int CntWidth = $clog2(NumSteps);
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [DataWidth-1:0] num;
    logic [DataWidth-1:0] den;
    logic neg_quot;
    logic neg_rem;
    logic zero;
  } job_t;

  typedef struct packed {
    logic [DataWidth-1:0] quotient;
    logic [DataWidth-1:0] remainder;
    logic divide_by_zero;
  } result_t;
endpackage
`default_nettype wire

[sv/div64_front.sv]
// Front end: accepts requests, takes magnitudes and queues division jobs.
`default_nettype none
module div64_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic operation,
  input  wire logic [div64_pkg::DataWidth-1:0] dividend,
  input  wire logic [div64_pkg::DataWidth-1:0] divisor,
  output logic job_valid,
  input  wire logic job_ready,
  output div64_pkg::job_t job
);
  import div64_pkg::*;

  job_t queue [QueueDepth];
  logic rd_ptr;
  logic wr_ptr;
  logic [1:0] count;
  job_t new_job;
  logic num_neg;
  logic den_neg;
  logic push;
  logic pop;

  assign num_neg = operation & dividend[DataWidth-1];
  assign den_neg = operation & divisor[DataWidth-1];

  always_comb begin
    new_job.num = num_neg ? (~dividend + 1'b1) : dividend;
    new_job.den = den_neg ? (~divisor + 1'b1) : divisor;
    new_job.neg_quot = num_neg ^ den_neg;
    new_job.neg_rem = num_neg;
    new_job.zero = (divisor == '0);
  end

  assign in_ready = (count != 2'(QueueDepth));
  assign job_valid = (count != 2'd0);
  assign job = queue[rd_ptr];
  assign push = in_valid & in_ready;
  assign pop = job_valid & job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_job;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

[sv/div64_back.sv]
// Back end: iterative restoring division, four quotient bits per cycle.
`default_nettype none
module div64_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic job_ready,
  input  wire div64_pkg::job_t job,
  output logic res_valid,
  input  wire logic res_ready,
  output div64_pkg::result_t res
);
  import div64_pkg::*;

  logic busy;
  logic [CntWidth-1:0] cnt;
  logic [DataWidth-1:0] rem;
  logic [DataWidth-1:0] quo;
  logic [DataWidth-1:0] den;
  logic neg_quot;
  logic neg_rem;
  logic zero;
  logic [DataWidth-1:0] rem_next;
  logic [DataWidth-1:0] quo_next;
  logic done;

  always_comb begin
    logic [DataWidth:0] r;
    r = {1'b0, rem};
    quo_next = quo;
    for (int i = 0; i < StepBits; i++) begin
      r = {r[DataWidth-1:0], quo_next[DataWidth-1]};
      quo_next = {quo_next[DataWidth-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        quo_next[0] = 1'b1;
      end
    end
    rem_next = r[DataWidth-1:0];
  end

  assign done = busy & (cnt == CntWidth'(NumSteps - 1));
  assign job_ready = ~busy & (~res_valid | res_ready);

  always_ff @(posedge clk) begin
    if (job_valid & job_ready) begin
      rem <= '0;
      quo <= job.num;
      den <= job.den;
      neg_quot <= job.neg_quot;
      neg_rem <= job.neg_rem;
      zero <= job.zero;
      cnt <= '0;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt + 1'b1;
    end
    if (done) begin
      res.divide_by_zero <= zero;
      res.quotient <= zero ? '0 : (neg_quot ? (~quo_next + 1'b1) : quo_next);
      res.remainder <= zero ? '0 : (neg_rem ? (~rem_next + 1'b1) : rem_next);
    end
    if (rst) begin
      busy <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (job_valid & job_ready) busy <= 1'b1;
      else if (done) busy <= 1'b0;
      if (done) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |=> res_valid)
    else $error("result not presented after last step");
  assert property (@(posedge clk) disable iff (rst) busy |-> !job_ready)
    else $error("job taken while busy");
  assert property (@(posedge clk) disable iff (rst) (res_valid && !res_ready) |=> res_valid)
    else $error("stalled result dropped");
endmodule
`default_nettype wire

[sv/divider_64bit_signed_unsigned_unit.sv]
// Top level of the 64-bit signed/unsigned divider.
// Requests arrive on the s_axis channel: tdata holds dividend then divisor,
// tuser holds the operation (0 unsigned, 1 signed). Results leave on m_axis:
// tdata holds quotient then remainder, tuser holds the divide-by-zero flag.
// The front end takes operand magnitudes and places a job in a two-entry
// queue; the back end divides four bits per cycle while busy and takes the
// next job only once it is idle and its result register is free, so it
// does not start a new division before the last one is finished.
// The front accepts up to two requests ahead while the back works or stalls.
// A stalled result holds in the output register and blocks the next job.
// Reset empties the queue and drops any division in flight.
`default_nettype none
module divider_64bit_signed_unsigned_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // dividend, divisor
  input  wire logic [0:0] s_axis_tuser,    // operation
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [127:0] m_axis_tdata,       // quotient, remainder
  output logic [0:0] m_axis_tuser          // divide_by_zero
);
  import div64_pkg::*;

  logic job_valid;
  logic job_ready;
  job_t job;
  result_t res;

  div64_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .operation(s_axis_tuser[0]),
    .dividend(s_axis_tdata[63:0]), .divisor(s_axis_tdata[127:64]),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  div64_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {res.remainder, res.quotient};
  assign m_axis_tuser = res.divide_by_zero;
endmodule
`default_nettype wire

[bench/tb_divider_64bit_signed_unsigned_unit.sv]
// Self-checking testbench for the 64-bit signed and unsigned divider unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_divider_64bit_signed_unsigned_unit;
  import div64_pkg::*;

  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED = 1'b1;
  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // dividend, divisor
  logic [0:0] s_axis_tuser = '0;    // operation
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;       // quotient, remainder
  logic [0:0] m_axis_tuser;         // divide_by_zero

  result_t expected_results[$];
  int error_count = 0;
  int burst_left = 0;
  bit stall_enable = 1'b1;

  divider_64bit_signed_unsigned_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #10 clk = ~clk;

  function automatic result_t divide_restoring(logic op, logic [63:0] num, logic [63:0] den);
    result_t res;
    logic [63:0] n, d, q, r;
    logic carry, num_neg, den_neg;
    res = '0;
    if (den == '0) begin
      res.divide_by_zero = 1'b1;
      return res;
    end
    num_neg = op && num[63];
    den_neg = op && den[63];
    n = num_neg ? -num : num;
    d = den_neg ? -den : den;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      carry = r[63];
      r = {r[62:0], n[b]};
      if (carry || r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    res.quotient = (num_neg != den_neg) ? -q : q;
    res.remainder = num_neg ? -r : r;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  task automatic send_request(logic op, logic [63:0] num, logic [63:0] den);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {den, num};
    s_axis_tuser <= op;
    expected_results.push_back(divide_restoring(op, num, den));
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    end_burst();
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!stall_enable) m_axis_tready <= 1'b1;
    else if ($urandom_range(0, 99) < 20) m_axis_tready <= ~m_axis_tready;
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[63:0] !== want.quotient)
          report_mismatch("quotient", m_axis_tdata[63:0], want.quotient);
        if (m_axis_tdata[127:64] !== want.remainder)
          report_mismatch("remainder", m_axis_tdata[127:64], want.remainder);
        if (m_axis_tuser[0] !== want.divide_by_zero)
          report_mismatch("divide_by_zero", 64'(m_axis_tuser),
                          64'(want.divide_by_zero));
      end
    end
  end

  task automatic test_special_cases();
    send_request(OP_UNSIGNED, 64'd100, 64'd0);
    send_request(OP_SIGNED, MIN_NEG, 64'd0);
    send_request(OP_SIGNED, MIN_NEG, ALL_ONES);
    send_request(OP_SIGNED, MIN_NEG, 64'd1);
    send_request(OP_UNSIGNED, ALL_ONES, MIN_NEG);
    send_request(OP_UNSIGNED, ALL_ONES, ALL_ONES);
    send_request(OP_UNSIGNED, ALL_ONES, 64'd1);
    send_request(OP_UNSIGNED, 64'd0, ALL_ONES);
    send_request(OP_UNSIGNED, 64'd5, 64'd7);
    send_request(OP_SIGNED, -64'sd7, 64'd2);
    send_request(OP_SIGNED, 64'd7, -64'sd2);
    send_request(OP_SIGNED, -64'sd7, -64'sd2);
    send_request(OP_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, MIN_NEG);
    send_request(OP_SIGNED, MIN_NEG, MIN_NEG);
    send_request(OP_UNSIGNED, MIN_NEG, 64'd3);
    wait_drained();
  endtask

  task automatic test_random_operands(int count);
    logic [63:0] num, den;
    int shift;
    for (int i = 0; i < count; i++) begin
      num = {$urandom, $urandom};
      den = {$urandom, $urandom};
      shift = $urandom_range(0, 63);
      if ($urandom_range(0, 2) == 0) den = den >> shift;
      if ($urandom_range(0, 40) == 0) den = '0;
      send_request(logic'($urandom_range(0, 1)), num, den);
    end
    wait_drained();
  endtask

  task automatic test_full_rate();
    stall_enable = 1'b0;
    for (int i = 0; i < 60; i++) begin
      burst_left = 100;
      send_request(logic'($urandom_range(0, 1)), {$urandom, $urandom}, {32'd0, $urandom});
    end
    wait_drained();
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_random_operands(900);
    test_full_rate();
    test_random_operands(875);
    repeat (40) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
